// ===== src/rqs_pkg.sv =====
package rqs_pkg;

    localparam int PROB_BITS          = 16;
    localparam int MAX_READ_LENGTH    = 1048576;
    localparam int MAX_WINDOW_DEFAULT = 1024;
    localparam int COUNT_W            = 21;
    localparam int TOTAL_W            = 37;
    localparam int SCORE_W            = 23;
    localparam int CFG_W              = 23;
    localparam int CFG_IDX_W          = 2;
    localparam int PERCENT            = 100;
    localparam int LENGTH_KNEE        = 5000;
    localparam int PHRED_OFFSET       = 33;
    localparam int PHRED_LEVELS       = 94;
    localparam int DIV_NW             = 48;
    localparam int DIV_DW             = 24;
    localparam int SQRT_TOP           = 46;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MEAN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW = 2'd3;

    localparam logic [1:0] VERDICT_PASS       = 2'd0;
    localparam logic [1:0] VERDICT_SHORT      = 2'd1;
    localparam logic [1:0] VERDICT_LOW_MEAN   = 2'd2;
    localparam logic [1:0] VERDICT_LOW_WINDOW = 2'd3;

    // Probability of a correct call for one Phred+33 byte, Q0.16.
    function automatic logic [PROB_BITS-1:0] prob_of(input logic [7:0] qbyte);
        logic [7:0] q;
        logic [PROB_BITS-1:0] p;
        q = qbyte - 8'(PHRED_OFFSET);
        unique case (q)
            8'd0:  p = 16'd0;
            8'd1:  p = 16'd13479;
            8'd2:  p = 16'd24186;
            8'd3:  p = 16'd32690;
            8'd4:  p = 16'd39446;
            8'd5:  p = 16'd44812;
            8'd6:  p = 16'd49074;
            8'd7:  p = 16'd52460;
            8'd8:  p = 16'd55149;
            8'd9:  p = 16'd57286;
            8'd10: p = 16'd58982;
            8'd11: p = 16'd60330;
            8'd12: p = 16'd61401;
            8'd13: p = 16'd62251;
            8'd14: p = 16'd62927;
            8'd15: p = 16'd63464;
            8'd16: p = 16'd63890;
            8'd17: p = 16'd64228;
            8'd18: p = 16'd64497;
            8'd19: p = 16'd64711;
            8'd20: p = 16'd64881;
            8'd21: p = 16'd65015;
            8'd22: p = 16'd65122;
            8'd23: p = 16'd65208;
            8'd24: p = 16'd65275;
            8'd25: p = 16'd65329;
            8'd26: p = 16'd65371;
            8'd27: p = 16'd65405;
            8'd28: p = 16'd65432;
            8'd29: p = 16'd65453;
            8'd30: p = 16'd65470;
            8'd31: p = 16'd65484;
            8'd32: p = 16'd65495;
            8'd33: p = 16'd65503;
            8'd34: p = 16'd65510;
            8'd35: p = 16'd65515;
            8'd36: p = 16'd65520;
            8'd37: p = 16'd65523;
            8'd38: p = 16'd65526;
            8'd39: p = 16'd65528;
            8'd40: p = 16'd65529;
            8'd41: p = 16'd65531;
            8'd42: p = 16'd65532;
            8'd43: p = 16'd65533;
            8'd44: p = 16'd65533;
            8'd45: p = 16'd65534;
            8'd46: p = 16'd65534;
            default: p = 16'd65535;
        endcase
        if (qbyte < 8'(PHRED_OFFSET) || qbyte >= 8'(PHRED_OFFSET + PHRED_LEVELS))
        begin
            p = '0;
        end
        return p;
    endfunction

endpackage

// ===== src/rqs_div.sv =====
module rqs_div #(
    parameter int NW = rqs_pkg::DIV_NW,
    parameter int DW = rqs_pkg::DIV_DW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] quo_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
                rem_reg  <= '0;
                den_reg  <= den;
                quo_reg  <= num;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/read_quality_scorer_unit.sv =====
// One quality byte is accepted whenever the unit is idle and is handled as a table lookup with
// a read of the window memory, then the update of the sums and the memory write. The item that
// ends a read then occupies the unit further, through up to four runs of the shift-subtract
// divider and 24 steps of the square root. The result waits in an output register, so the
// next read may start before it is taken.
module read_quality_scorer_unit #(
    parameter int MAX_WINDOW = rqs_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [7:0]                             quality_byte,
    input  logic                                   byte_present,
    input  logic                                   last_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [rqs_pkg::SCORE_W-1:0]            final_score,
    output logic [rqs_pkg::SCORE_W-1:0]            mean_score,
    output logic [rqs_pkg::SCORE_W-1:0]            window_score,
    output logic [rqs_pkg::COUNT_W-1:0]            read_length,
    output logic [1:0]                             verdict,
    input  logic                                   cfg_we,
    input  logic [rqs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rqs_pkg::CFG_W-1:0]              cfg_data
);

    localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WLW = $clog2(MAX_WINDOW + 1);
    localparam int PB  = rqs_pkg::PROB_BITS;
    localparam int WSW = PB + WLW;
    localparam int CW  = rqs_pkg::COUNT_W;
    localparam int TW  = rqs_pkg::TOTAL_W;
    localparam int SW  = rqs_pkg::SCORE_W;
    localparam int NW  = rqs_pkg::DIV_NW;
    localparam int DW  = rqs_pkg::DIV_DW;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_MEAN, S_MEAN_W, S_WIN, S_WIN_W, S_LS, S_LS_W,
        S_MUL1, S_SQRT, S_MUL2, S_FDIV, S_FDIV_W, S_OUT
    } state_t;

    state_t         state_reg;
    logic [10:0]    cfg_window_reg;
    logic [CW-1:0]  cfg_min_len_reg;
    logic [SW-1:0]  cfg_min_mean_reg;
    logic [SW-1:0]  cfg_min_win_reg;

    logic [PB-1:0]  p_reg;
    logic           take_reg;
    logic           last_reg;
    logic [TW-1:0]  total_reg;
    logic [WSW-1:0] wsum_reg;
    logic [WSW-1:0] least_reg;
    logic [CW-1:0]  count_reg;
    logic [AW-1:0]  wptr_reg;
    logic [WLW-1:0] aw_reg;

    logic [SW-1:0]  mean_reg;
    logic [SW-1:0]  win_reg;
    logic [SW-1:0]  ls_reg;
    logic [SW-1:0]  final_reg;
    logic [NW-1:0]  prod_reg;
    logic [NW-1:0]  root_reg;
    logic [NW-1:0]  bit_reg;

    logic           out_valid_reg;
    logic [SW-1:0]  out_final_reg;
    logic [SW-1:0]  out_mean_reg;
    logic [SW-1:0]  out_win_reg;
    logic [CW-1:0]  out_len_reg;
    logic [1:0]     out_verdict_reg;

    logic [PB-1:0]  hist_mem [MAX_WINDOW];
    logic [PB-1:0]  rd_data_reg;

    logic           accept;
    logic [31:0]    wclamp;
    logic [AW:0]    old_sum;
    logic [AW-1:0]  old_addr;
    logic           full_window;
    logic [WSW-1:0] wsum_new;
    logic [AW-1:0]  wptr_inc;
    logic           len_le_win;
    logic [SW-1:0]  capped;
    logic [1:0]     verdict_calc;
    logic [23:0]    mul_a;
    logic [23:0]    mul_b;
    logic [47:0]    mul_p;
    logic [NW-1:0]  sq_trial;
    logic           div_start;
    logic [NW-1:0]  div_num;
    logic [DW-1:0]  div_den;
    logic           div_done;
    logic [NW-1:0]  div_q;
    logic [CW:0]    knee_sum;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        wclamp = 32'(cfg_window_reg);
        if (wclamp == 32'd0)
        begin
            wclamp = 32'd1;
        end
        if (wclamp > 32'(MAX_WINDOW))
        begin
            wclamp = 32'(MAX_WINDOW);
        end
    end

    always_comb
    begin
        old_sum = {1'b0, wptr_reg} + (AW+1)'(MAX_WINDOW) - (AW+1)'(aw_reg);
        if (old_sum >= (AW+1)'(MAX_WINDOW))
        begin
            old_sum = old_sum - (AW+1)'(MAX_WINDOW);
        end
        old_addr = old_sum[AW-1:0];
    end

    assign wptr_inc    = (wptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : wptr_reg + 1'b1;
    assign full_window = 32'(count_reg) >= 32'(aw_reg);
    assign wsum_new    = full_window ? wsum_reg + WSW'(p_reg) - WSW'(rd_data_reg)
                                     : wsum_reg + WSW'(p_reg);
    assign len_le_win  = 32'(count_reg) <= 32'(aw_reg);
    assign capped      = (win_reg < mean_reg) ? win_reg : mean_reg;
    assign sq_trial    = root_reg + bit_reg;
    assign knee_sum    = {1'b0, count_reg} + (CW+1)'(rqs_pkg::LENGTH_KNEE);

    always_comb
    begin
        if (count_reg < cfg_min_len_reg)
        begin
            verdict_calc = rqs_pkg::VERDICT_SHORT;
        end
        else if (cfg_min_mean_reg != '0 && mean_reg < cfg_min_mean_reg)
        begin
            verdict_calc = rqs_pkg::VERDICT_LOW_MEAN;
        end
        else if (cfg_min_win_reg != '0 && win_reg < cfg_min_win_reg)
        begin
            verdict_calc = rqs_pkg::VERDICT_LOW_WINDOW;
        end
        else
        begin
            verdict_calc = rqs_pkg::VERDICT_PASS;
        end
    end

    always_comb
    begin
        if (state_reg == S_MUL2)
        begin
            mul_a = 24'(root_reg);
            mul_b = 24'(mean_reg) + 24'(capped);
        end
        else
        begin
            mul_a = 24'(ls_reg);
            mul_b = 24'(mean_reg);
        end
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_MEAN:
            begin
                div_start = (count_reg != '0);
                div_num   = NW'(total_reg) * NW'(rqs_pkg::PERCENT) + NW'(count_reg >> 1);
                div_den   = DW'(count_reg);
            end
            S_WIN:
            begin
                div_start = !len_le_win;
                div_num   = NW'(least_reg) * NW'(rqs_pkg::PERCENT) + NW'(aw_reg >> 1);
                div_den   = DW'(aw_reg);
            end
            S_LS:
            begin
                div_start = (mean_reg != '0);
                div_num   = ((NW'(count_reg) * NW'(rqs_pkg::PERCENT)) << 16)
                            + NW'(knee_sum >> 1);
                div_den   = DW'(knee_sum);
            end
            S_FDIV:
            begin
                div_start = 1'b1;
                div_num   = prod_reg + NW'(mean_reg);
                div_den   = {mean_reg, 1'b0};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    rqs_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        rd_data_reg <= hist_mem[old_addr];
        if (state_reg == S_UPD && take_reg)
        begin
            hist_mem[wptr_reg] <= p_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cfg_window_reg   <= 11'd250;
            cfg_min_len_reg  <= '0;
            cfg_min_mean_reg <= '0;
            cfg_min_win_reg  <= '0;
            p_reg            <= '0;
            take_reg         <= 1'b0;
            last_reg         <= 1'b0;
            total_reg        <= '0;
            wsum_reg         <= '0;
            least_reg        <= '0;
            count_reg        <= '0;
            wptr_reg         <= '0;
            aw_reg           <= WLW'(1);
            mean_reg         <= '0;
            win_reg          <= '0;
            ls_reg           <= '0;
            final_reg        <= '0;
            prod_reg         <= '0;
            root_reg         <= '0;
            bit_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_final_reg    <= '0;
            out_mean_reg     <= '0;
            out_win_reg      <= '0;
            out_len_reg      <= '0;
            out_verdict_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rqs_pkg::REG_WINDOW:     cfg_window_reg   <= cfg_data[10:0];
                    rqs_pkg::REG_MIN_LENGTH: cfg_min_len_reg  <= cfg_data[CW-1:0];
                    rqs_pkg::REG_MIN_MEAN:   cfg_min_mean_reg <= cfg_data;
                    rqs_pkg::REG_MIN_WINDOW: cfg_min_win_reg  <= cfg_data;
                    default:                 cfg_min_win_reg  <= cfg_min_win_reg;
                endcase
            end

            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        p_reg    <= rqs_pkg::prob_of(quality_byte);
                        take_reg <= byte_present
                                    && (32'(count_reg) < 32'(rqs_pkg::MAX_READ_LENGTH));
                        last_reg <= last_byte;
                        if (byte_present && count_reg == '0)
                        begin
                            aw_reg   <= wclamp[WLW-1:0];
                            wptr_reg <= '0;
                        end
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (take_reg)
                    begin
                        total_reg <= total_reg + TW'(p_reg);
                        wsum_reg  <= wsum_new;
                        if ((full_window && wsum_new < least_reg)
                            || (32'(count_reg) + 32'd1 == 32'(aw_reg)))
                        begin
                            least_reg <= wsum_new;
                        end
                        wptr_reg  <= wptr_inc;
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= last_reg ? S_MEAN : S_IDLE;
                end
                S_MEAN:
                begin
                    if (count_reg == '0)
                    begin
                        mean_reg  <= '0;
                        win_reg   <= '0;
                        final_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_MEAN_W;
                    end
                end
                S_MEAN_W:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= div_q[SW-1:0];
                        state_reg <= S_WIN;
                    end
                end
                S_WIN:
                begin
                    if (len_le_win)
                    begin
                        win_reg   <= mean_reg;
                        state_reg <= S_LS;
                    end
                    else
                    begin
                        state_reg <= S_WIN_W;
                    end
                end
                S_WIN_W:
                begin
                    if (div_done)
                    begin
                        win_reg   <= div_q[SW-1:0];
                        state_reg <= S_LS;
                    end
                end
                S_LS:
                begin
                    if (mean_reg == '0)
                    begin
                        final_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_LS_W;
                    end
                end
                S_LS_W:
                begin
                    if (div_done)
                    begin
                        ls_reg    <= div_q[SW-1:0];
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    prod_reg  <= NW'(mul_p);
                    root_reg  <= '0;
                    bit_reg   <= NW'(1) << rqs_pkg::SQRT_TOP;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        state_reg <= S_MUL2;
                    end
                    else
                    begin
                        if (prod_reg >= sq_trial)
                        begin
                            prod_reg <= prod_reg - sq_trial;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_MUL2:
                begin
                    prod_reg  <= NW'(mul_p);
                    state_reg <= S_FDIV;
                end
                S_FDIV:
                begin
                    state_reg <= S_FDIV_W;
                end
                S_FDIV_W:
                begin
                    if (div_done)
                    begin
                        final_reg <= div_q[SW-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_final_reg   <= final_reg;
                        out_mean_reg    <= mean_reg;
                        out_win_reg     <= win_reg;
                        out_len_reg     <= count_reg;
                        out_verdict_reg <= verdict_calc;
                        total_reg       <= '0;
                        wsum_reg        <= '0;
                        least_reg       <= '0;
                        count_reg       <= '0;
                        wptr_reg        <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign final_score  = out_final_reg;
    assign mean_score   = out_mean_reg;
    assign window_score = out_win_reg;
    assign read_length  = out_len_reg;
    assign verdict      = out_verdict_reg;

endmodule

// ===== bench/read_quality_scorer_unit_tb.sv =====
module read_quality_scorer_unit_tb;

    typedef struct packed {
        logic [7:0] qbyte;
        logic       present;
        logic       last;
    } base_item_t;

    typedef struct packed {
        logic [rqs_pkg::SCORE_W-1:0] final_score;
        logic [rqs_pkg::SCORE_W-1:0] mean_score;
        logic [rqs_pkg::SCORE_W-1:0] window_score;
        logic [rqs_pkg::COUNT_W-1:0] read_length;
        logic [1:0]                  verdict;
    } read_score_t;

    localparam int WINDOW_DEPTH = rqs_pkg::MAX_WINDOW_DEFAULT;
    localparam int IDLE_SETTLE  = 400;
    localparam int STALL_LIMIT  = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] quality_byte;
    logic byte_present;
    logic last_byte;
    logic out_valid;
    logic out_stall;
    logic [rqs_pkg::SCORE_W-1:0] final_score;
    logic [rqs_pkg::SCORE_W-1:0] mean_score;
    logic [rqs_pkg::SCORE_W-1:0] window_score;
    logic [rqs_pkg::COUNT_W-1:0] read_length;
    logic [1:0] verdict;
    logic cfg_we;
    logic [rqs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rqs_pkg::CFG_W-1:0] cfg_data;

    read_quality_scorer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .quality_byte(quality_byte), .byte_present(byte_present), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .final_score(final_score), .mean_score(mean_score),
        .window_score(window_score), .read_length(read_length), .verdict(verdict),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    base_item_t  pending_bases[$];
    read_score_t expected_scores[$];
    int          failures = 0;

    // Shadow of the scorer state.
    logic [15:0]        history [WINDOW_DEPTH];
    longint unsigned    total_sum = 0;
    longint unsigned    window_sum = 0;
    longint unsigned    least_sum = 0;
    longint unsigned    bases_seen = 0;
    int unsigned        write_slot = 0;
    int unsigned        latched_window = 1;
    int unsigned        shadow_window = 250;
    longint unsigned    shadow_min_len = 0;
    longint unsigned    shadow_min_mean = 0;
    longint unsigned    shadow_min_win = 0;

    initial
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            history[i] = '0;
        end
    end

    function automatic longint unsigned correct_prob(input logic [7:0] qb);
        longint unsigned nano [10] = '{1000000000, 794328235, 630957344, 501187234, 398107171,
                                       316227766, 251188643, 199526231, 158489319, 125892541};
        longint unsigned den;
        longint unsigned err;
        int unsigned q;
        if (qb < rqs_pkg::PHRED_OFFSET
            || qb >= rqs_pkg::PHRED_OFFSET + rqs_pkg::PHRED_LEVELS)
        begin
            return 0;
        end
        q = qb - rqs_pkg::PHRED_OFFSET;
        den = 64'd1000000000;
        for (int i = 0; i < q / 10; i++)
        begin
            den = den * 10;
        end
        err = ((nano[q % 10] << rqs_pkg::PROB_BITS) + den / 2) / den;
        if (err >= (64'd1 << rqs_pkg::PROB_BITS))
        begin
            return 0;
        end
        if (err == 0)
        begin
            return (64'd1 << rqs_pkg::PROB_BITS) - 1;
        end
        return (64'd1 << rqs_pkg::PROB_BITS) - err;
    endfunction

    function automatic longint unsigned percent_score(input longint unsigned sum,
                                                      input longint unsigned count);
        longint unsigned num;
        num = sum * rqs_pkg::PERCENT;
        return (num + count / 2) / count;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitval;
        root = 0;
        bitval = 64'd1 << 62;
        while (bitval > v)
        begin
            bitval = bitval >> 2;
        end
        while (bitval != 0)
        begin
            if (v >= root + bitval)
            begin
                v = v - (root + bitval);
                root = (root >> 1) + bitval;
            end
            else
            begin
                root = root >> 1;
            end
            bitval = bitval >> 2;
        end
        return root;
    endfunction

    function automatic int unsigned effective_window(input int unsigned w);
        if (w == 0)
        begin
            return 1;
        end
        if (w > WINDOW_DEPTH)
        begin
            return WINDOW_DEPTH;
        end
        return w;
    endfunction

    task automatic score_base(input base_item_t it);
        longint unsigned p;
        longint unsigned len;
        longint unsigned mean;
        longint unsigned win;
        longint unsigned fin;
        longint unsigned ls;
        longint unsigned root;
        longint unsigned capped;
        read_score_t res;
        int unsigned old;
        if (it.present && bases_seen < rqs_pkg::MAX_READ_LENGTH)
        begin
            if (bases_seen == 0)
            begin
                latched_window = effective_window(shadow_window);
                write_slot = 0;
            end
            p = correct_prob(it.qbyte);
            total_sum += p;
            if (bases_seen >= latched_window)
            begin
                old = (write_slot + WINDOW_DEPTH - latched_window) % WINDOW_DEPTH;
                window_sum = window_sum + p - history[old];
                if (window_sum < least_sum)
                begin
                    least_sum = window_sum;
                end
            end
            else
            begin
                window_sum += p;
            end
            history[write_slot] = p[15:0];
            write_slot = (write_slot + 1) % WINDOW_DEPTH;
            bases_seen++;
            if (bases_seen == latched_window)
            begin
                least_sum = window_sum;
            end
        end
        if (it.last)
        begin
            len = bases_seen;
            mean = 0;
            win = 0;
            fin = 0;
            if (len > 0)
            begin
                mean = percent_score(total_sum, len);
                win = (len <= latched_window) ? mean : percent_score(least_sum, latched_window);
                if (mean > 0)
                begin
                    ls = ((len * rqs_pkg::PERCENT) << 16);
                    ls = (ls + (len + rqs_pkg::LENGTH_KNEE) / 2) / (len + rqs_pkg::LENGTH_KNEE);
                    root = floor_root(ls * mean);
                    capped = (win < mean) ? win : mean;
                    fin = (root * (mean + capped) + mean) / (2 * mean);
                end
            end
            res.final_score = fin[rqs_pkg::SCORE_W-1:0];
            res.mean_score = mean[rqs_pkg::SCORE_W-1:0];
            res.window_score = win[rqs_pkg::SCORE_W-1:0];
            res.read_length = len[rqs_pkg::COUNT_W-1:0];
            if (len < shadow_min_len)
            begin
                res.verdict = rqs_pkg::VERDICT_SHORT;
            end
            else if (shadow_min_mean != 0 && mean < shadow_min_mean)
            begin
                res.verdict = rqs_pkg::VERDICT_LOW_MEAN;
            end
            else if (shadow_min_win != 0 && win < shadow_min_win)
            begin
                res.verdict = rqs_pkg::VERDICT_LOW_WINDOW;
            end
            else
            begin
                res.verdict = rqs_pkg::VERDICT_PASS;
            end
            expected_scores.insert(expected_scores.size(), res);
            total_sum = 0;
            window_sum = 0;
            least_sum = 0;
            bases_seen = 0;
            write_slot = 0;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    base_item_t next_base;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            quality_byte <= '0;
            byte_present <= 1'b0;
            last_byte <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_bases.size() > 0)
            begin
                next_base = pending_bases.pop_front();
                quality_byte <= next_base.qbyte;
                byte_present <= next_base.present;
                last_byte <= next_base.last;
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 400)
                                                           : $urandom_range(0, 12);
                    gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: modes of random length.
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 600);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= ($urandom_range(0, 7) != 0);
                default: out_stall <= ((mode_left / 40) % 2 == 0);
            endcase
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                score_base(base_item_t'{quality_byte, byte_present, last_byte});
            end
            if (out_valid && !out_stall)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("unexpected result, final_score %0d", final_score);
                    failures++;
                end
                else
                begin
                    read_score_t e;
                    e = expected_scores.pop_front();
                    if (final_score !== e.final_score)
                    begin
                        $error("final_score expected %0d actual %0d", e.final_score, final_score);
                        failures++;
                    end
                    if (mean_score !== e.mean_score)
                    begin
                        $error("mean_score expected %0d actual %0d",
                               e.mean_score, mean_score);
                        failures++;
                    end
                    if (window_score !== e.window_score)
                    begin
                        $error("window_score expected %0d actual %0d",
                               e.window_score, window_score);
                        failures++;
                    end
                    if (read_length !== e.read_length)
                    begin
                        $error("read_length expected %0d actual %0d", e.read_length, read_length);
                        failures++;
                    end
                    if (verdict !== e.verdict)
                    begin
                        $error("verdict expected %0d actual %0d", e.verdict, verdict);
                        failures++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(input logic [rqs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rqs_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            rqs_pkg::REG_WINDOW:     shadow_window = val & 23'h7FF;
            rqs_pkg::REG_MIN_LENGTH: shadow_min_len = val & 23'h1FFFFF;
            rqs_pkg::REG_MIN_MEAN:   shadow_min_mean = val;
            default:                 shadow_min_win = val;
        endcase
    endtask

    task automatic wait_idle();
        @(posedge clk);
        #1;
        while (pending_bases.size() > 0 || in_valid || expected_scores.size() > 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned ml,
                             input int unsigned mm, input int unsigned mw);
        wait_idle();
        write_reg(rqs_pkg::REG_WINDOW, rqs_pkg::CFG_W'(w));
        write_reg(rqs_pkg::REG_MIN_LENGTH, rqs_pkg::CFG_W'(ml));
        write_reg(rqs_pkg::REG_MIN_MEAN, rqs_pkg::CFG_W'(mm));
        write_reg(rqs_pkg::REG_MIN_WINDOW, rqs_pkg::CFG_W'(mw));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] random_qbyte();
        if ($urandom_range(0, 6) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            return 8'($urandom_range(33, 45));
        end
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic queue_base(input logic [7:0] qb, input logic pr, input logic lb);
        pending_bases.insert(pending_bases.size(), base_item_t'{qb, pr, lb});
    endtask

    task automatic queue_read(input int unsigned len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                queue_base(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            queue_base(random_qbyte(), 1'b1, (i == len - 1));
        end
        if (len == 0 || $urandom_range(0, 9) == 0)
        begin
            queue_base(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned w;
        int unsigned len;
        int unsigned sent;
        w = effective_window(shadow_window);
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(0, 9)) inside
                [0:5]:   len = $urandom_range(0, 30);
                [6:7]:   len = (w > 300) ? $urandom_range(1, 60)
                                         : $urandom_range(w > 2 ? w - 2 : 0, w + 20);
                8:       len = $urandom_range(1, 120);
                default: len = (w > 300) ? $urandom_range(w - 2, w + 30)
                                         : $urandom_range(1, 4);
            endcase
            queue_read(len);
            sent += len + 1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Byte range edges, a one-base read, an empty read, a zero-quality read and noise.
        queue_base(8'd0, 1'b1, 1'b0);
        queue_base(8'd32, 1'b1, 1'b0);
        queue_base(8'd33, 1'b1, 1'b0);
        queue_base(8'd126, 1'b1, 1'b0);
        queue_base(8'd127, 1'b1, 1'b0);
        queue_base(8'd255, 1'b1, 1'b0);
        queue_base(8'hAA, 1'b0, 1'b0);
        queue_base(8'h55, 1'b1, 1'b1);
        queue_base(8'd73, 1'b1, 1'b1);
        queue_base(8'hFF, 1'b0, 1'b1);
        queue_base(8'd33, 1'b1, 1'b0);
        queue_base(8'd33, 1'b1, 1'b1);
        queue_base(8'd126, 1'b1, 1'b0);
        queue_base(8'd126, 1'b1, 1'b0);
        queue_base(8'd0, 1'b0, 1'b1);

        configure(0, 3, 6000000, 0);
        queue_read(1);
        queue_read(4);
        queue_read(0);
        random_phase(150);

        configure(1, 0, 0, 6553600);
        random_phase(200);

        configure(2047, 0, 6553600, 6553600);
        random_phase(250);

        configure(1024, 1048576, 0, 0);
        queue_read(3);
        queue_read(0);

        configure(1024, 0, 3000000, 5000000);
        random_phase(600);

        for (int ph = 0; ph < 5; ph++)
        begin
            configure($urandom_range(1, 40), $urandom_range(0, 25),
                      $urandom_range(0, 1) ? 0 : $urandom_range(4000000, 6553600),
                      $urandom_range(0, 1) ? 0 : $urandom_range(3000000, 6553600));
            random_phase(200);
        end

        configure(250, 2097151 & 23'h1FFFFF, 8388607, 8388607);
        queue_read(2);

        wait_idle();
        if (expected_scores.size() > 0)
        begin
            $error("%0d results never arrived", expected_scores.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
